// File: src/calendar_date_to_unix_seconds_unit_macros.svh
// ----------------------------------------------------------------------------
// calendar date to unix seconds: assertion macros
// Concurrent assertion wrappers on clk_i, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_TO_UNIX_SECONDS_UNIT_MACROS_SVH
`define CALENDAR_DATE_TO_UNIX_SECONDS_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// checked outside reset
`define CDTU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every edge, reset included
`define CDTU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CDTU_ASSERT(label, prop, msg)
`define CDTU_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: src/cdtu_pkg.sv
// ----------------------------------------------------------------------------
// cdtu_pkg
// Types, constants and calendar tables shared by the date conversion unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdtu_pkg;

  localparam int unsigned YearW = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW = 5;
  localparam int unsigned HoursW = 5;
  localparam int unsigned MinutesW = 6;
  localparam int unsigned SecondsW = 6;
  localparam int unsigned ResultW = 38;
  localparam int unsigned QuotW = 8;
  localparam int unsigned ProdW = 27;
  localparam int unsigned RecipShift = 19;

  localparam logic [YearW-1:0] EpochYear = 14'd1970;
  localparam logic [12:0] Recip100 = 13'd5243;  // ceil(2^19 / 100)
  localparam logic [ResultW-1:0] DaysPerYear = 38'd365;
  localparam logic [ResultW-1:0] LeapsBeforeEpoch = 38'd477;  // leap years in 1..1969
  localparam logic [ResultW-1:0] SecsPerHour = 38'd3600;
  localparam logic [ResultW-1:0] SecsPerMinute = 38'd60;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_YEARS,
    ST_LEAP4,
    ST_LEAP100,
    ST_LEAP400,
    ST_EPOCH,
    ST_MONTH,
    ST_DAY,
    ST_MUL16,
    ST_MUL14,
    ST_MUL12,
    ST_MUL8,
    ST_MUL7,
    ST_HOURS,
    ST_MINUTES,
    ST_SECONDS,
    ST_DONE
  } step_e;

  typedef struct packed {
    step_e step;
    logic  load;
    logic  finish;
  } ctrl_t;

  function automatic logic month_bad(input logic [MonthW-1:0] month);
    month_bad = (month == 4'd0) || (month > 4'd12);
  endfunction

  // days in the whole months before the given one, common year
  function automatic logic [8:0] days_before_month(input logic [MonthW-1:0] month);
    logic [8:0] d;
    unique case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    days_before_month = d;
  endfunction

endpackage

// File: src/cdtu_seq.sv
// ----------------------------------------------------------------------------
// cdtu_seq
// Step sequencer driving the shared accumulator, one term per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdtu_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           bad_month_i,
  input  logic           out_free_i,
  output cdtu_pkg::ctrl_t ctrl_o
);
  import cdtu_pkg::*;

  step_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = bad_month_i ? ST_DONE : ST_YEARS;
        end
      end
      ST_YEARS:   state_d = ST_LEAP4;
      ST_LEAP4:   state_d = ST_LEAP100;
      ST_LEAP100: state_d = ST_LEAP400;
      ST_LEAP400: state_d = ST_EPOCH;
      ST_EPOCH:   state_d = ST_MONTH;
      ST_MONTH:   state_d = ST_DAY;
      ST_DAY:     state_d = ST_MUL16;
      ST_MUL16:   state_d = ST_MUL14;
      ST_MUL14:   state_d = ST_MUL12;
      ST_MUL12:   state_d = ST_MUL8;
      ST_MUL8:    state_d = ST_MUL7;
      ST_MUL7:    state_d = ST_HOURS;
      ST_HOURS:   state_d = ST_MINUTES;
      ST_MINUTES: state_d = ST_SECONDS;
      ST_SECONDS: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o.step   = state_q;
    ctrl_o.load   = (state_q == ST_IDLE) && in_valid_i;
    ctrl_o.finish = (state_q == ST_DONE) && out_free_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/cdtu_datapath.sv
// ----------------------------------------------------------------------------
// cdtu_datapath
// Request registers, shared add/subtract accumulator and the divide-by-100
// reciprocal multiplier used for the leap year count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdtu_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cdtu_pkg::ctrl_t                    ctrl_i,
  input  logic [cdtu_pkg::YearW-1:0]         year_i,
  input  logic [cdtu_pkg::MonthW-1:0]        month_i,
  input  logic [cdtu_pkg::DayW-1:0]          day_i,
  input  logic [cdtu_pkg::HoursW-1:0]        hours_i,
  input  logic [cdtu_pkg::MinutesW-1:0]      minutes_i,
  input  logic [cdtu_pkg::SecondsW-1:0]      seconds_i,
  input  logic                               bad_month_i,
  output logic [cdtu_pkg::ResultW-1:0]       result_o,
  output logic                               error_o
);
  import cdtu_pkg::*;

  logic [YearW-1:0]    year_q;
  logic [MonthW-1:0]   month_q;
  logic [DayW-1:0]     day_q;
  logic [HoursW-1:0]   hours_q;
  logic [MinutesW-1:0] minutes_q;
  logic [SecondsW-1:0] seconds_q;
  logic                err_q;

  logic [ResultW-1:0]  acc_q, acc_d;
  logic [ResultW-1:0]  days_q;
  logic [QuotW-1:0]    qn_q, qy_q;

  logic [ResultW-1:0]  acc_in;
  logic [ResultW-1:0]  operand;
  logic                sub;
  logic                acc_en;

  logic                after_epoch;
  logic [YearW-1:0]    nyears;
  logic [YearW-1:0]    prev_year;
  logic [YearW-1:0]    mul_in;
  logic [ProdW-1:0]    prod;
  logic                century;
  logic                leap;
  logic [8:0]          month_days;

  assign after_epoch = year_q > EpochYear;
  assign nyears      = year_q - EpochYear;
  assign prev_year   = year_q - 14'd1;

  // floor(x / 100) by reciprocal, exact over the whole 14-bit range
  assign mul_in = (ctrl_i.step == ST_YEARS) ? prev_year : year_q;
  assign prod   = ProdW'(mul_in) * ProdW'(Recip100);

  // a century year is one where the hundreds count steps up
  assign century    = (qy_q != qn_q);
  assign leap       = (year_q[1:0] == 2'd0) && (!century || (qy_q[1:0] == 2'd0));
  assign month_days = days_before_month(month_q) + 9'((leap && (month_q >= 4'd3)) ? 1 : 0);

  always_comb begin
    operand = '0;
    sub     = 1'b0;
    acc_en  = 1'b1;
    acc_in  = acc_q;
    unique case (ctrl_i.step)
      ST_YEARS:   operand = after_epoch ? ResultW'(nyears) * DaysPerYear : '0;
      ST_LEAP4:   operand = after_epoch ? ResultW'(prev_year[YearW-1:2]) : '0;
      ST_LEAP100: begin
        operand = after_epoch ? ResultW'(qn_q) : '0;
        sub     = 1'b1;
      end
      ST_LEAP400: operand = after_epoch ? ResultW'(qn_q[QuotW-1:2]) : '0;
      ST_EPOCH: begin
        operand = after_epoch ? LeapsBeforeEpoch : '0;
        sub     = 1'b1;
      end
      ST_MONTH:   operand = ResultW'(month_days);
      ST_DAY:     operand = ResultW'(day_q) - 38'd1;
      // days * 86400 as a sum of five shifted copies
      ST_MUL16: begin
        acc_in  = '0;
        operand = days_q << 16;
      end
      ST_MUL14:   operand = days_q << 14;
      ST_MUL12:   operand = days_q << 12;
      ST_MUL8:    operand = days_q << 8;
      ST_MUL7:    operand = days_q << 7;
      ST_HOURS:   operand = ResultW'(hours_q) * SecsPerHour;
      ST_MINUTES: operand = ResultW'(minutes_q) * SecsPerMinute;
      ST_SECONDS: operand = ResultW'(seconds_q);
      ST_IDLE,
      ST_DONE:    acc_en = 1'b0;
      default:    acc_en = 1'b0;
    endcase
  end

  // subtract by inverting the operand with the carry in
  assign acc_d = acc_in + (operand ^ {ResultW{sub}}) + ResultW'(sub);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      year_q    <= year_i;
      month_q   <= month_i;
      day_q     <= day_i;
      hours_q   <= hours_i;
      minutes_q <= minutes_i;
      seconds_q <= seconds_i;
    end
    if (ctrl_i.step == ST_YEARS) begin
      qn_q <= prod[ProdW-1:RecipShift];
    end
    if (ctrl_i.step == ST_LEAP4) begin
      qy_q <= prod[ProdW-1:RecipShift];
    end
    if (ctrl_i.step == ST_DAY) begin
      days_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      err_q <= 1'b0;
    end else if (ctrl_i.load) begin
      acc_q <= '0;
      err_q <= bad_month_i;
    end else if (acc_en) begin
      acc_q <= acc_d;
    end
  end

  assign result_o = acc_q;
  assign error_o  = err_q;

endmodule

// File: src/calendar_date_to_unix_seconds_unit.sv
// ----------------------------------------------------------------------------
// calendar_date_to_unix_seconds_unit
// Converts a Gregorian UTC date and time of day in 1970 or later into seconds since 1970-01-01.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       request    in_valid_i / in_stall_o   year, month, day, hours, minutes, seconds
//  out      result     out_valid_o / out_stall_i unix_seconds, input_error
//
//  a new request is stalled until the last one finishes; its 15 terms are summed
//  one per cycle through the single shared accumulator
//  a bad month skips the sum
//  the result sits in an output register, so a new request is taken while it waits
//  a stalled output holds the sequencer in its last step until the register frees
//  reset clears the sequencer, the accumulator and the output valid
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "calendar_date_to_unix_seconds_unit_macros.svh"

module calendar_date_to_unix_seconds_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [cdtu_pkg::YearW-1:0]         year_i,
  input  logic [cdtu_pkg::MonthW-1:0]        month_i,
  input  logic [cdtu_pkg::DayW-1:0]          day_i,
  input  logic [cdtu_pkg::HoursW-1:0]        hours_i,
  input  logic [cdtu_pkg::MinutesW-1:0]      minutes_i,
  input  logic [cdtu_pkg::SecondsW-1:0]      seconds_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [cdtu_pkg::ResultW-1:0]       unix_seconds_o,
  output logic                               input_error_o
);
  import cdtu_pkg::*;

  ctrl_t              ctrl;
  logic               bad_month;
  logic               out_free;
  logic [ResultW-1:0] acc;
  logic               err;

  logic               out_valid_q;
  logic [ResultW-1:0] unix_seconds_q;
  logic               input_error_q;

  assign bad_month  = month_bad(month_i);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (ctrl.step != ST_IDLE);

  cdtu_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .bad_month_i (bad_month),
    .out_free_i  (out_free),
    .ctrl_o      (ctrl)
  );

  cdtu_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .year_i      (year_i),
    .month_i     (month_i),
    .day_i       (day_i),
    .hours_i     (hours_i),
    .minutes_i   (minutes_i),
    .seconds_i   (seconds_i),
    .bad_month_i (bad_month),
    .result_o    (acc),
    .error_o     (err)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.finish) begin
      unix_seconds_q <= acc;
      input_error_q  <= err;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign unix_seconds_o = unix_seconds_q;
  assign input_error_o  = input_error_q;

  `CDTU_ASSERT(a_err_result_zero, out_valid_o && input_error_o |-> unix_seconds_o == '0, "error result not zero")
  `CDTU_ASSERT(a_bad_month_skips, in_valid_i && !in_stall_o && bad_month |=> ctrl.step == ST_DONE, "bad month did not skip the sum")
  `CDTU_ASSERT(a_accept_busy, in_valid_i && !in_stall_o |=> in_stall_o, "request accepted while sequencer idle after accept")
  `CDTU_ASSERT_ALWAYS(a_load_from_done, ctrl.finish |-> ctrl.step == ST_DONE && out_free, "result loaded outside the final step")

endmodule

// File: tb/calendar_date_to_unix_seconds_unit_tb.sv
// ----------------------------------------------------------------------------
// calendar_date_to_unix_seconds_unit_tb
// Self-checking bench for the date to epoch-seconds unit. A queue-fed driver
// sends date requests under random valid gaps, and a monitor stalls the result
// side at random. Each accepted result is checked against an in-bench
// calculation of the same date, in request order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module calendar_date_to_unix_seconds_unit_tb;

  import cdtu_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned RandomDates = 1900;
  localparam int unsigned PhaseCount = 3;
  localparam int unsigned MaxReports = 10;

  localparam logic [MonthW-1:0] MonNone = 4'd0;
  localparam logic [MonthW-1:0] MonJan = 4'd1;
  localparam logic [MonthW-1:0] MonFeb = 4'd2;
  localparam logic [MonthW-1:0] MonMar = 4'd3;
  localparam logic [MonthW-1:0] MonDec = 4'd12;
  localparam logic [MonthW-1:0] MonMax = 4'd15;

  localparam logic [63:0] EpochYr = 64'd1970;
  localparam logic [63:0] SecsPerDay = 64'd86400;
  localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // idle percentages per phase
  localparam int unsigned SendIdlePct [PhaseCount] = '{12, 55, 0};
  localparam int unsigned RecvStallPct [PhaseCount] = '{55, 12, 0};

  typedef struct {
    logic [YearW-1:0]    year;
    logic [MonthW-1:0]   month;
    logic [DayW-1:0]     day;
    logic [HoursW-1:0]   hours;
    logic [MinutesW-1:0] minutes;
    logic [SecondsW-1:0] seconds;
    int unsigned         phase;
    bit                  drain_first;
  } date_req_t;

  typedef struct {
    logic [ResultW-1:0] unix_seconds;
    logic               input_error;
  } epoch_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [YearW-1:0] year_i = '0;
  logic [MonthW-1:0] month_i = '0;
  logic [DayW-1:0] day_i = '0;
  logic [HoursW-1:0] hours_i = '0;
  logic [MinutesW-1:0] minutes_i = '0;
  logic [SecondsW-1:0] seconds_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [ResultW-1:0] unix_seconds_o;
  logic input_error_o;

  date_req_t pending_dates[$];
  epoch_result_t awaited_seconds[$];

  int unsigned cur_phase = 0;
  int unsigned calm_cycles = 0;
  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  int unsigned sent_count = 0;
  int unsigned bad_month_count = 0;
  int unsigned checked_count = 0;

  calendar_date_to_unix_seconds_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .year_i         (year_i),
    .month_i        (month_i),
    .day_i          (day_i),
    .hours_i        (hours_i),
    .minutes_i      (minutes_i),
    .seconds_i      (seconds_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .unix_seconds_o (unix_seconds_o),
    .input_error_o  (input_error_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic bit year_has_feb29(logic [63:0] y);
    if (y % 4 != 0) return 1'b0;
    return (y % 100 != 0) || (y % 400 == 0);
  endfunction

  function automatic logic [63:0] leap_years_through(logic [63:0] n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic epoch_result_t date_to_epoch_seconds(date_req_t r);
    epoch_result_t res;
    logic [63:0] y;
    logic [63:0] days;
    logic [63:0] total;
    y = 64'(r.year);
    days = '0;
    res.unix_seconds = '0;
    res.input_error = 1'b0;
    if (r.month == MonNone || r.month > MonDec) begin
      res.input_error = 1'b1;
      return res;
    end
    if (y > EpochYr)
      days = (y - EpochYr) * 365 + leap_years_through(y - 1) - leap_years_through(EpochYr - 1);
    for (int unsigned m = 0; m + 1 < r.month; m++) begin
      days += MonthDays[m];
      if (m + 1 == MonFeb && year_has_feb29(y)) days += 1;
    end
    // day zero lands one day before the first, wrapping below zero
    days = days + 64'(r.day) - 64'd1;
    total = days * SecsPerDay + 64'(r.hours) * 3600 + 64'(r.minutes) * 60 + 64'(r.seconds);
    res.unix_seconds = total[ResultW-1:0];
    return res;
  endfunction

  function automatic date_req_t mk_date(int unsigned y, int unsigned mo, int unsigned d,
                                        int unsigned h, int unsigned mi, int unsigned s);
    date_req_t r;
    r.year = y[YearW-1:0];
    r.month = mo[MonthW-1:0];
    r.day = d[DayW-1:0];
    r.hours = h[HoursW-1:0];
    r.minutes = mi[MinutesW-1:0];
    r.seconds = s[SecondsW-1:0];
    r.phase = 0;
    r.drain_first = 1'b0;
    return r;
  endfunction

  // mostly plausible dates, some raw noise across every field bit
  function automatic date_req_t random_date();
    date_req_t r;
    int unsigned y;
    int unsigned mo;
    int unsigned dmax;
    if ($urandom_range(99) < 15) begin
      r = mk_date($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      y = ($urandom_range(3) == 0) ? $urandom_range(9999, 1970) : $urandom_range(2110, 1970);
      mo = $urandom_range(MonDec, MonJan);
      dmax = MonthDays[mo - 1];
      if (mo == MonFeb && year_has_feb29(64'(y))) dmax = 29;
      if ($urandom_range(9) == 0) dmax = 31;
      r = mk_date(y, mo, $urandom_range(dmax, 1), $urandom_range(23), $urandom_range(59),
                  $urandom_range(60));
    end
    return r;
  endfunction

  initial begin
    date_req_t r;
    // epoch itself, then the first of every month of a leap year
    pending_dates.push_back(mk_date(1970, MonJan, 1, 0, 0, 0));
    for (int unsigned m = MonJan; m <= MonDec; m++)
      pending_dates.push_back(mk_date(2024, m, 1, 12, 30, 30));
    // leap day edges, including century rules
    pending_dates.push_back(mk_date(2024, MonFeb, 29, 23, 59, 59));
    pending_dates.push_back(mk_date(2000, MonMar, 1, 0, 0, 0));
    pending_dates.push_back(mk_date(1900, MonMar, 1, 0, 0, 0));
    pending_dates.push_back(mk_date(2100, MonFeb, 28, 23, 59, 59));
    pending_dates.push_back(mk_date(9999, MonDec, 31, 23, 59, 60));
    // bad months
    pending_dates.push_back(mk_date(2024, MonNone, 15, 10, 10, 10));
    pending_dates.push_back(mk_date(2024, MonDec + 1, 15, 10, 10, 10));
    pending_dates.push_back(mk_date(16383, MonMax, 31, 31, 63, 63));
    // years before the epoch, day zero wrap, overflow with unchecked time of day
    pending_dates.push_back(mk_date(0, MonMar, 1, 0, 0, 0));
    pending_dates.push_back(mk_date(1969, MonDec, 31, 23, 59, 59));
    pending_dates.push_back(mk_date(1970, MonJan, 0, 0, 0, 0));
    pending_dates.push_back(mk_date(16383, MonDec, 31, 31, 63, 63));

    for (int unsigned i = 0; i < RandomDates; i++) begin
      r = random_date();
      r.phase = (i * PhaseCount) / RandomDates;
      r.drain_first = (i == 0) || ((i * PhaseCount) % RandomDates < PhaseCount) ||
                      ($urandom_range(199) == 0);
      pending_dates.push_back(r);
    end

    wait (rst_ni);
    while (pending_dates.size() != 0 || in_valid_i || awaited_seconds.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (awaited_seconds.size() != 0) begin
      fail_count++;
      $display("%0d results never arrived", awaited_seconds.size());
    end

    $display("sent %0d date requests (%0d with a bad month), checked %0d results",
             sent_count, bad_month_count, checked_count);
    $display("covered leap and century rules, pre-epoch years, day zero and field overflow");
    if (fail_count == 0) begin
      $display("calendar_date_to_unix_seconds_unit_tb OK");
    end else begin
      $display("calendar_date_to_unix_seconds_unit_tb NOT OK");
    end
    $finish;
  end

  // request driver
  always @(posedge clk_i) begin
    bit hold;
    bit idle;
    date_req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (calm_cycles != 0) calm_cycles <= calm_cycles - 1;
      else if ($urandom_range(249) == 0) calm_cycles <= 60;

      hold = in_valid_i && in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        awaited_seconds.push_back(date_to_epoch_seconds(pending_dates[0]));
        if (pending_dates[0].month == MonNone || pending_dates[0].month > MonDec)
          bad_month_count++;
        sent_count++;
        void'(pending_dates.pop_front());
      end

      if (!hold) begin
        idle = 1'b1;
        if (pending_dates.size() != 0) begin
          nxt = pending_dates[0];
          idle = (calm_cycles == 0) && ($urandom_range(99) < SendIdlePct[nxt.phase]);
          // hold off until every outstanding result is back
          if (nxt.drain_first && awaited_seconds.size() != 0) idle = 1'b1;
        end
        if (!idle) begin
          cur_phase <= nxt.phase;
          in_valid_i <= 1'b1;
          year_i <= nxt.year;
          month_i <= nxt.month;
          day_i <= nxt.day;
          hours_i <= nxt.hours;
          minutes_i <= nxt.minutes;
          seconds_i <= nxt.seconds;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and stall generator
  always @(posedge clk_i) begin
    epoch_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= (calm_cycles == 0) && ($urandom_range(99) < RecvStallPct[cur_phase]);
      if (out_valid_o && !out_stall_i) begin
        if (awaited_seconds.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("unexpected result: unix_seconds %0d input_error %0b",
                     unix_seconds_o, input_error_o);
        end else begin
          want = awaited_seconds.pop_front();
          checked_count++;
          if (unix_seconds_o !== want.unix_seconds || input_error_o !== want.input_error) begin
            fail_count++;
            if (fail_count <= MaxReports)
              $display("mismatch on result %0d: unix_seconds %0d/%0d input_error %0b/%0b",
                       checked_count, unix_seconds_o, want.unix_seconds,
                       input_error_o, want.input_error);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timed out after %0d cycles", cycle_count);
      $display("calendar_date_to_unix_seconds_unit_tb NOT OK");
      $finish;
    end
  end

endmodule
